@@ src/assert_macros.svh @@
// Assertion macros for the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset
`define B64D_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define B64D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64D_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ src/b64d_pkg.sv @@
// Shared types, constants and the alphabet lookup for the Base64 decoder
`default_nettype none

package b64d_pkg;

    localparam int unsigned SYM_W    = 8;
    localparam int unsigned SEXT_W   = 6;
    localparam int unsigned CAP_W    = 24;
    localparam int unsigned CNT_W    = CAP_W + 1;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QIDX_W   = $clog2(QDEPTH);

    localparam logic [SYM_W-1:0] PAD_CHAR  = 8'h3D;
    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_SMALL = 2'd2
    } t_status;

    // One classified character on its way from front to back
    typedef struct packed {
        logic [1:0]        n_zero;   // held pads released as zero sextets
        logic              has_sym;  // one further sextet follows them
        logic [SEXT_W-1:0] value;    // value of that sextet
        logic              is_last;  // closes the stream
        logic              is_short; // no character came before it in the stream
    } t_entry;

    // Standard alphabet, unknown characters give zero
    function automatic logic [SEXT_W-1:0] sextet_of(input logic [SYM_W-1:0] c);
        logic [SEXT_W-1:0] v;
        v = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            v = SEXT_W'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = SEXT_W'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            v = SEXT_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 6'd62;
        end else if (c == 8'h2F) begin
            v = 6'd63;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/b64d_if.sv @@
// Valid/ready channel interfaces for characters in and results out
`default_nettype none

interface b64d_sym_if;
    import b64d_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             is_last;

    modport source (output valid, output symbol, output is_last, input ready);
    modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface b64d_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_stream;
    logic [1:0] status;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_stream, output status, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_stream, input status, output ready);
endinterface

`default_nettype wire

@@ src/base64_stream_decoder.sv @@
// Top level of the Base64 stream decoder: front, queue and back joined
//
//  Channel   Dir  Handshake        Payload
//  i_sym     in   valid/ready      symbol[7:0], is_last
//  o_res     out  valid/ready      data_byte[7:0], byte_valid, end_of_stream, status[1:0]
//  i_cfg_*   in   write enable     out_capacity[23:0]
//
// One character is taken per cycle while the four-entry queue has room.
// The back end decodes one sextet per cycle while its output register can take a result:
// a held pad yields none, another character one, or up to three when held pads are released ahead of it.
// A character's first result passes through the queue and the output register before it is presented.
// Reset is synchronous, active low; capacity resets to all ones.
// Either side may stall; the queue and the output register keep the other moving.
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    b64d_sym_if.sink              i_sym,
    b64d_res_if.source            o_res
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   q_full;
    logic   pop;
    logic   head_valid;

    b64d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sym    (i_sym),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    b64d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_entry),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head       (head_entry),
        .o_head_valid (head_valid)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_head       (head_entry),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

@@ src/b64d_queue.sv @@
// Short queue of classified characters between front and back
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_push_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_head_valid
);

    t_entry             r_mem [QDEPTH];
    logic [QIDX_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QIDX_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QIDX_W:0]    r_count,  n_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_full       = (r_count == (QIDX_W+1)'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_pop && o_head_valid;

    // pointer and fill arithmetic
    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!push_ok && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/b64d_front.sv @@
// Front end: takes characters, maps the alphabet and holds back pad runs
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    b64d_sym_if.sink  i_sym,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_entry    o_entry
);

    logic [1:0] r_held, n_held;
    logic       r_seen, n_seen;
    logic       is_pad;

    assign i_sym.ready = !i_q_full;
    assign o_push      = i_sym.valid && !i_q_full;
    assign is_pad      = (i_sym.symbol == PAD_CHAR);

    // classify the character and update the pad hold
    always_comb begin
        o_entry          = '0;
        o_entry.is_last  = i_sym.is_last;
        o_entry.is_short = !r_seen;
        n_held           = r_held;
        if (is_pad) begin
            if (r_held == 2'd2) begin
                // oldest held pad falls out as a zero sextet
                o_entry.has_sym = 1'b1;
            end else begin
                n_held = r_held + 2'd1;
            end
        end else begin
            o_entry.n_zero  = r_held;
            o_entry.has_sym = 1'b1;
            o_entry.value   = sextet_of(i_sym.symbol);
            n_held          = '0;
        end
        n_seen = 1'b1;
        // trailing pads are dropped at stream end
        if (i_sym.is_last) begin
            n_held = '0;
            n_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_seen <= 1'b0;
        end else if (o_push) begin
            r_held <= n_held;
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire

@@ src/b64d_back.sv @@
// Back end: one sextet a cycle unless the output stalls, into bytes, capacity check and final status
`default_nettype none

`include "assert_macros.svh"

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  wire t_entry           i_head,
    input  wire logic             i_head_valid,
    output logic                  o_pop,
    b64d_res_if.source            o_res
);

    logic [CAP_W-1:0]  r_cap;
    logic [1:0]        r_pos;
    logic [SEXT_W-1:0] r_prev;
    logic [CNT_W-1:0]  r_count;
    logic [1:0]        r_idx;
    logic              r_any;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_bv;
    logic              r_out_eos;
    t_status           r_out_status;

    logic              adv;
    logic [1:0]        n_sext;
    logic              no_sext;
    logic              fin;
    logic [1:0]        rem;
    logic [SEXT_W-1:0] cur_v;
    logic              inc_now;
    logic [CNT_W:0]    sum1;
    logic [CNT_W-1:0]  c1;
    logic              c1_fits;
    logic              produce;
    logic              later_prod;
    logic [7:0]        byte_val;
    logic [1:0]        steps;
    logic              zero_in;
    logic [1:0]        tot_inc;
    logic [CNT_W:0]    sum_f;
    logic [CNT_W-1:0]  fin_cnt;
    logic [1:0]        fin_pos;
    t_status           st;
    logic              eos_here;
    logic              emit;
    logic              emit_eos;
    logic              close_stream;

    assign adv     = i_head_valid && (!r_out_valid || o_res.ready);
    assign n_sext  = i_head.n_zero + {1'b0, i_head.has_sym};
    assign no_sext = (n_sext == 2'd0);
    assign rem     = n_sext - 2'd1 - r_idx;
    assign fin     = no_sext || (rem == 2'd0);
    assign o_pop   = adv && fin;

    // current sextet and whether it yields a byte
    assign cur_v   = (r_idx < i_head.n_zero) ? '0 : i_head.value;
    assign inc_now = (r_pos != 2'd0);
    assign sum1    = {1'b0, r_count} + (CNT_W+1)'(inc_now);
    assign c1      = sum1[CNT_W] ? {CNT_W{1'b1}} : sum1[CNT_W-1:0];
    assign c1_fits = (c1 < {1'b0, r_cap});
    assign produce = !no_sext && inc_now && (r_count < {1'b0, r_cap});

    // a later sextet of this character emits iff the count still fits and a
    // non-zero quartet position comes up
    assign later_prod = (rem != 2'd0) && c1_fits
                        && (((r_pos + 2'd1) != 2'd0) || (rem == 2'd2));

    always_comb begin
        case (r_pos)
            2'd1:    byte_val = {r_prev, cur_v[5:4]};
            2'd2:    byte_val = {r_prev[3:0], cur_v[5:2]};
            2'd3:    byte_val = {r_prev[1:0], cur_v};
            default: byte_val = '0;
        endcase
    end

    // state as it stands once the whole character is decoded
    always_comb begin
        steps   = no_sext ? 2'd0 : rem + 2'd1;
        zero_in = !no_sext
                  && ((r_pos == 2'd0) || (({1'b0, r_pos} + {1'b0, rem}) >= 3'd4));
        tot_inc = steps - {1'b0, zero_in};
        sum_f   = {1'b0, r_count} + (CNT_W+1)'(tot_inc);
        fin_cnt = sum_f[CNT_W] ? {CNT_W{1'b1}} : sum_f[CNT_W-1:0];
        fin_pos = r_pos + steps;
        if (i_head.is_short || (fin_pos == 2'd1)) begin
            st = ST_INVALID;
        end else if (fin_cnt > {1'b0, r_cap}) begin
            st = ST_TOO_SMALL;
        end else begin
            st = ST_OK;
        end
    end

    // end flag rides on the last byte, or on an empty result
    assign eos_here     = i_head.is_last && !later_prod;
    assign emit_eos     = fin && i_head.is_last && !r_any && !produce;
    assign emit         = produce || emit_eos;
    assign close_stream = adv && fin && i_head.is_last;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_prev  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_any   <= 1'b0;
        end else if (adv) begin
            if (close_stream) begin
                r_pos   <= '0;
                r_prev  <= '0;
                r_count <= '0;
                r_idx   <= '0;
                r_any   <= 1'b0;
            end else begin
                if (!no_sext) begin
                    r_pos   <= r_pos + 2'd1;
                    r_prev  <= cur_v;
                    r_count <= c1;
                end
                r_idx <= fin ? 2'd0 : r_idx + 2'd1;
                r_any <= fin ? 1'b0 : (r_any || produce);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out_byte   <= produce ? byte_val : 8'h00;
            r_out_bv     <= produce;
            r_out_eos    <= produce ? eos_here : 1'b1;
            r_out_status <= (produce && !eos_here) ? ST_OK : st;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.data_byte     = r_out_byte;
    assign o_res.byte_valid    = r_out_bv;
    assign o_res.end_of_stream = r_out_eos;
    assign o_res.status        = r_out_status;

    `B64D_ASSERT(a_empty_is_eos, i_clk, i_rst_n, (o_res.valid && !o_res.byte_valid) |-> (o_res.end_of_stream && o_res.data_byte == 8'h00), "empty result without end flag")
    `B64D_ASSERT(a_status_on_eos, i_clk, i_rst_n, (o_res.valid && o_res.status != ST_OK) |-> o_res.end_of_stream, "status outside final result")
    `B64D_NEVER(a_idx_range, i_clk, i_rst_n, i_head_valid && !no_sext && r_idx >= n_sext, "sextet index beyond character")
    `B64D_ASSERT(a_stream_clears, i_clk, i_rst_n, close_stream |=> (r_pos == 2'd0 && r_count == '0 && !r_any), "stream state not cleared")

endmodule

`default_nettype wire
